### rtl/rau_pkg.sv
package rau_pkg;

    localparam int WIDTH_DEF = 32;
    localparam int FW        = 32;   // fixed width of the operand and result fields
    localparam int PW        = 64;   // magnitude width of a cross product

    typedef enum logic [2:0] {
        MODE_ADD = 3'd0,
        MODE_SUB = 3'd1,
        MODE_MUL = 3'd2,
        MODE_DIV = 3'd3,
        MODE_LT  = 3'd4,
        MODE_GT  = 3'd5,
        MODE_EQ  = 3'd6,
        MODE_NOP = 3'd7
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_OVF  = 2'd1,
        ST_ZERO = 2'd2
    } status_t;

    // Serial multiplier control and result.
    typedef struct packed {
        logic        start;
        logic [31:0] x;
        logic [31:0] y;
    } mul_req_t;

    typedef struct packed {
        logic          done;
        logic [PW-1:0] p;
    } mul_rsp_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_M1,
        S_M2,
        S_M3,
        S_SUM,
        S_GCD,
        S_DIVN,
        S_DIVD,
        S_CHECK,
        S_OUT
    } state_t;

endpackage

### rtl/rau_mul.sv
// Shift-and-add multiplier of two 32-bit magnitudes, one bit per cycle.
module rau_mul (
    input  logic              clk,
    input  logic              rst_n,
    input  rau_pkg::mul_req_t req,
    output rau_pkg::mul_rsp_t rsp
);
    import rau_pkg::*;

    logic [PW-1:0] acc_reg, acc_next;
    logic [PW-1:0] mcand_reg, mcand_next;
    logic [31:0]   mplier_reg, mplier_next;
    logic [5:0]    cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;

    always_comb
    begin
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        cnt_next    = cnt_reg;
        busy_next   = busy_reg;
        done_next   = 1'b0;
        if (req.start)
        begin
            acc_next    = '0;
            mcand_next  = {32'd0, req.x};
            mplier_next = req.y;
            cnt_next    = '0;
            busy_next   = 1'b1;
        end
        else if (busy_reg)
        begin
            if (mplier_reg[0])
                acc_next = acc_reg + mcand_reg;
            mcand_next  = mcand_reg << 1;
            mplier_next = mplier_reg >> 1;
            cnt_next    = cnt_reg + 6'd1;
            if (cnt_reg == 6'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
    end

    assign rsp.done = done_reg;
    assign rsp.p    = acc_reg;
endmodule

### rtl/rau_div.sv
// Restoring divider of 64-bit magnitudes, one quotient bit per cycle.
module rau_div (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [rau_pkg::PW-1:0] dividend,
    input  logic [rau_pkg::PW-1:0] divisor,
    output logic                 done,
    output logic [rau_pkg::PW-1:0] quot,
    output logic [rau_pkg::PW-1:0] rem
);
    import rau_pkg::*;

    logic [PW-1:0] q_reg, q_next;
    logic [PW-1:0] r_reg, r_next;
    logic [PW-1:0] d_reg, d_next;
    logic [6:0]    cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [PW:0]   trial;

    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {r_reg, q_reg[PW-1]};
        if (start)
        begin
            q_next    = dividend;
            r_next    = '0;
            d_next    = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            q_next = {q_reg[PW-2:0], 1'b0};
            if (trial >= {1'b0, d_reg})
            begin
                r_next    = PW'(trial - {1'b0, d_reg});
                q_next[0] = 1'b1;
            end
            else
                r_next = trial[PW-1:0];
            cnt_next = cnt_reg + 7'd1;
            if (cnt_reg == 7'(PW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign done = done_reg;
    assign quot = q_reg;
    assign rem  = r_reg;
endmodule

### rtl/rational_arith_unit_core.sv
// Rational ALU: one word in, one word out, one word at a time. Cross products
// come from a bit-serial multiplier (three per word), and the reduction uses a
// bit-serial divider for every Euclid step and for the two final divisions by
// the GCD. The number of Euclid steps depends on the operands and can reach
// about 90 on full-width products. Compare modes, mode 7 and a 0/0 result skip
// the divider. A finished word waits in the output register until taken; the
// next input word can be accepted in the cycle after it has been delivered.
module rational_arith_unit_core #(
    parameter int WIDTH = rau_pkg::WIDTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  mode,
    input  logic signed [31:0] a_num,
    input  logic signed [31:0] a_den,
    input  logic signed [31:0] b_num,
    input  logic signed [31:0] b_den,
    output logic        out_valid,
    input  logic        out_ready,
    output logic signed [31:0] res_num,
    output logic signed [31:0] res_den,
    output logic        cmp_true,
    output logic [1:0]  status
);
    import rau_pkg::*;

    state_t state_reg, state_next;

    mode_t         mode_reg;
    logic [31:0]   an_m, ad_m, bn_m, bd_m;
    logic          an_s, ad_s, bn_s, bd_s;
    logic [31:0]   anm_reg, adm_reg, bnm_reg, bdm_reg;
    logic          ans_reg, ads_reg, bns_reg, bds_reg;
    logic [PW-1:0] p1_reg, p2_reg;
    logic          s1_reg, s2_reg, s3_reg;
    logic [PW-1:0] nm_reg, dm_reg;
    logic          nn_reg, dn_reg;
    logic [PW-1:0] gx_reg, gy_reg;
    logic [PW-1:0] qn_reg;

    logic          ovf;
    logic [31:0]   rn_reg, rd_reg;
    logic          rc_reg;
    status_t       rs_reg;

    mul_req_t mreq;
    mul_rsp_t mrsp;
    logic          dstart;
    logic [PW-1:0] ddvd, ddvs;
    logic          ddone;
    logic [PW-1:0] dquot, drem;

    logic          x_neg, y_neg;
    logic [PW-1:0] sum_mag;
    logic          sum_neg;
    logic          lt, eq;
    logic [PW-1:0] half;
    logic          fit_n, fit_d;

    assign an_m = a_num[31] ? 32'(-a_num) : a_num;
    assign ad_m = a_den[31] ? 32'(-a_den) : a_den;
    assign bn_m = b_num[31] ? 32'(-b_num) : b_num;
    assign bd_m = b_den[31] ? 32'(-b_den) : b_den;
    assign an_s = a_num[31];
    assign ad_s = a_den[31];
    assign bn_s = b_num[31];
    assign bd_s = b_den[31];

    rau_mul u_mul (.clk(clk), .rst_n(rst_n), .req(mreq), .rsp(mrsp));

    rau_div u_div (
        .clk(clk), .rst_n(rst_n), .start(dstart), .dividend(ddvd), .divisor(ddvs),
        .done(ddone), .quot(dquot), .rem(drem)
    );

    // Signed sum of the first two products, second one negated for subtract.
    always_comb
    begin
        x_neg = s1_reg && (p1_reg != '0);
        y_neg = (s2_reg ^ (mode_reg == MODE_SUB)) && (p2_reg != '0);
        if (x_neg == y_neg)
        begin
            sum_mag = p1_reg + p2_reg;
            sum_neg = x_neg;
        end
        else if (p1_reg >= p2_reg)
        begin
            sum_mag = p1_reg - p2_reg;
            sum_neg = x_neg;
        end
        else
        begin
            sum_mag = p2_reg - p1_reg;
            sum_neg = y_neg;
        end
        if (sum_mag == '0)
            sum_neg = 1'b0;
    end

    // Compare lhs = an*bd (p1) against rhs = bn*ad (p2).
    always_comb
    begin
        eq = (p1_reg == p2_reg) || (p1_reg == '0 && p2_reg == '0);
        if (p1_reg == '0 && p2_reg == '0)
            eq = 1'b1;
        else
            eq = (p1_reg == p2_reg) && (s1_reg == s2_reg);
        if (eq)
            lt = 1'b0;
        else if ((s1_reg && p1_reg != '0) != (s2_reg && p2_reg != '0))
            lt = s1_reg && p1_reg != '0;
        else if (s1_reg && p1_reg != '0)
            lt = p1_reg > p2_reg;
        else
            lt = p1_reg < p2_reg;
    end

    assign half  = PW'(1) << (WIDTH - 1);
    assign fit_n = nn_reg ? (qn_reg <= half) : (qn_reg < half);
    assign fit_d = dn_reg ? (dquot <= half) : (dquot < half);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (in_valid) state_next = S_M1;
            S_M1:    if (mrsp.done) state_next = S_M2;
            S_M2:    if (mrsp.done) state_next = S_M3;
            S_M3:    if (mrsp.done) state_next = S_SUM;
            S_SUM:
            begin
                if (mode_reg inside {MODE_LT, MODE_GT, MODE_EQ, MODE_NOP})
                    state_next = S_OUT;
                else if (nm_reg == '0 && dm_reg == '0)
                    state_next = S_OUT;
                else if (dm_reg == '0)
                    state_next = S_DIVN;
                else
                    state_next = S_GCD;
            end
            S_GCD:   if (ddone && drem == '0) state_next = S_DIVN;
            S_DIVN:  if (ddone) state_next = S_DIVD;
            S_DIVD:  if (ddone) state_next = S_CHECK;
            S_CHECK: state_next = S_OUT;
            S_OUT:   if (out_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Unit controls.
    always_comb
    begin
        in_ready  = (state_reg == S_IDLE);
        out_valid = (state_reg == S_OUT);
        mreq      = '0;
        dstart    = 1'b0;
        ddvd      = gx_reg;
        ddvs      = gy_reg;
        case (state_reg)
            S_IDLE:
            begin
                mreq.start = in_valid;
                mreq.x     = an_m;
                mreq.y     = bd_m;
            end
            S_M1:
            begin
                mreq.start = mrsp.done;
                if (mode_reg == MODE_MUL)
                begin
                    mreq.x = bnm_reg;
                    mreq.y = anm_reg;
                end
                else
                begin
                    mreq.x = bnm_reg;
                    mreq.y = adm_reg;
                end
            end
            S_M2:
            begin
                mreq.start = mrsp.done;
                if (mode_reg == MODE_DIV)
                begin
                    mreq.x = adm_reg;
                    mreq.y = bnm_reg;
                end
                else
                begin
                    mreq.x = adm_reg;
                    mreq.y = bdm_reg;
                end
            end
            S_SUM:
            begin
                dstart = !(mode_reg inside {MODE_LT, MODE_GT, MODE_EQ, MODE_NOP})
                         && (nm_reg != '0 || dm_reg != '0);
                if (dm_reg == '0)
                begin
                    ddvd = nm_reg;
                    ddvs = nm_reg;
                end
                else
                begin
                    ddvd = nm_reg;
                    ddvs = dm_reg;
                end
            end
            S_GCD:
            begin
                dstart = ddone;
                if (drem == '0)
                begin
                    ddvd = nm_reg;
                    ddvs = gy_reg;
                end
                else
                begin
                    ddvd = gy_reg;
                    ddvs = drem;
                end
            end
            S_DIVN:
            begin
                dstart = ddone;
                ddvd   = dm_reg;
                ddvs   = gy_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                mode_reg <= mode_t'(mode);
                anm_reg <= an_m; adm_reg <= ad_m; bnm_reg <= bn_m; bdm_reg <= bd_m;
                ans_reg <= an_s; ads_reg <= ad_s; bns_reg <= bn_s; bds_reg <= bd_s;
                s1_reg  <= an_s ^ bd_s;
            end
            S_M1:
                if (mrsp.done)
                begin
                    p1_reg <= mrsp.p;
                    s2_reg <= (mode_reg == MODE_MUL) ? (bns_reg ^ ans_reg)
                                                     : (bns_reg ^ ads_reg);
                end
            S_M2:
                if (mrsp.done)
                begin
                    p2_reg <= mrsp.p;
                    s3_reg <= (mode_reg == MODE_DIV) ? (ads_reg ^ bns_reg)
                                                     : (ads_reg ^ bds_reg);
                end
            S_M3:
                if (mrsp.done)
                begin
                    dm_reg <= mrsp.p;
                    dn_reg <= s3_reg && (mrsp.p != '0);
                    if (mode_reg == MODE_ADD || mode_reg == MODE_SUB)
                    begin
                        nm_reg <= sum_mag;
                        nn_reg <= sum_neg;
                    end
                    else if (mode_reg == MODE_MUL)
                    begin
                        nm_reg <= p2_reg;
                        nn_reg <= s2_reg && (p2_reg != '0);
                    end
                    else
                    begin
                        nm_reg <= p1_reg;
                        nn_reg <= s1_reg && (p1_reg != '0);
                    end
                end
            S_SUM:
            begin
                rn_reg <= '0;
                rd_reg <= '0;
                case (mode_reg)
                    MODE_LT: rc_reg <= lt;
                    MODE_GT: rc_reg <= !lt && !eq;
                    MODE_EQ: rc_reg <= eq;
                    default: rc_reg <= 1'b0;
                endcase
                if (!(mode_reg inside {MODE_LT, MODE_GT, MODE_EQ, MODE_NOP})
                    && nm_reg == '0 && dm_reg == '0)
                    rs_reg <= ST_ZERO;
                else
                    rs_reg <= ST_OK;
                gx_reg <= nm_reg;
                gy_reg <= (dm_reg == '0) ? nm_reg : dm_reg;
            end
            S_GCD:
                if (ddone && drem != '0)
                begin
                    gx_reg <= gy_reg;
                    gy_reg <= drem;
                end
            S_DIVN:
                if (ddone)
                    qn_reg <= dquot;
            S_CHECK: ;
            default: ;
        endcase
        if (state_reg == S_DIVD && ddone)
        begin
            if (fit_n && fit_d)
            begin
                rn_reg <= nn_reg ? 32'(-qn_reg) : qn_reg[31:0];
                rd_reg <= dn_reg ? 32'(-dquot) : dquot[31:0];
            end
            else
                rs_reg <= ST_OVF;
        end
    end

    assign ovf      = (rs_reg == ST_OVF);
    assign res_num  = ovf ? '0 : rn_reg;
    assign res_den  = ovf ? '0 : rd_reg;
    assign cmp_true = rc_reg;
    assign status   = rs_reg;
endmodule

### rtl/rau_checker.sv
module rau_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] res_num,
    input logic [31:0] res_den,
    input logic        cmp_true,
    input logic [1:0]  status
);
    import rau_pkg::*;

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input taken while a result waits");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(res_num) && $stable(status))
        else $error("result changed while stalled");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> res_num == '0 && res_den == '0 && !cmp_true)
        else $error("error result with nonzero fields");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status != 2'd3)
        else $error("unknown status code");
endmodule

bind rational_arith_unit_core rau_checker u_rau_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .res_num(res_num),
    .res_den(res_den), .cmp_true(cmp_true), .status(status)
);
